// File: rtl/core/pf74_pkg.sv
// ----------------------------------------------------------------------------
// pf74_pkg: shared types and constants of the 7x4 Playfair cipher
// Symbol codes, command codes, character constants, memory control
// structs and the character conversion functions.
// ----------------------------------------------------------------------------
`default_nettype none

package pf74_pkg;

  // Symbol codes: 0..25 are a..z, 26..35 are 0..9, 63 marks an empty cell.
  localparam int SYM_W       = 6;
  localparam int NSYM        = 36;
  localparam int NUM_LETTERS = 26;
  localparam int GRID_COLS   = 4;
  localparam int COL_W       = 2;

  localparam logic [SYM_W-1:0] CODE_I    = 6'd8;
  localparam logic [SYM_W-1:0] CODE_J    = 6'd9;
  localparam logic [SYM_W-1:0] CODE_X    = 6'd23;
  localparam logic [SYM_W-1:0] CODE_NONE = 6'd63;
  localparam logic [SYM_W-1:0] CODE_D0   = 6'd26;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_Z     = 8'h7A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  typedef enum logic [2:0] {
    CMD_KEY_START = 3'd0,
    CMD_KEY_CHAR  = 3'd1,
    CMD_KEY_DONE  = 3'd2,
    CMD_ENC_CHAR  = 3'd3,
    CMD_DEC_CHAR  = 3'd4,
    CMD_END_MSG   = 3'd5
  } cmd_t;

  // Control of the symbol-to-cell map.
  typedef struct packed {
    logic             clr;
    logic             we;
    logic             re;
    logic [SYM_W-1:0] waddr;
    logic [SYM_W-1:0] raddr;
  } place_ctl_t;

  // Control of the grid memory (addresses travel separately, their width
  // follows the grid size).
  typedef struct packed {
    logic             we;
    logic             re;
    logic [SYM_W-1:0] wdata;
  } grid_ctl_t;

  // Lower-case a character and turn it into a symbol code; j keeps its code.
  function automatic logic [SYM_W-1:0] sym_code(input logic [7:0] c);
    logic [7:0] l;
    logic [7:0] d;
    l = (c >= CH_UA && c <= CH_UZ) ? c + CASE_OFS : c;
    d = '0;
    if (l >= CH_A && l <= CH_Z) begin
      d = l - CH_A;
      return d[SYM_W-1:0];
    end else if (l >= CH_0 && l <= CH_9) begin
      d = l - CH_0;
      return CODE_D0 + d[SYM_W-1:0];
    end
    return CODE_NONE;
  endfunction

  // Character of a symbol code; the empty code gives zero.
  function automatic logic [7:0] code_char(input logic [SYM_W-1:0] code);
    logic [7:0] w;
    w = {2'b00, code};
    if (code < SYM_W'(NUM_LETTERS)) begin
      return CH_A + w;
    end else if (code < SYM_W'(NSYM)) begin
      return CH_0 + (w - {2'b00, CODE_D0});
    end
    return 8'h00;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/pf74_in_if.sv
// ----------------------------------------------------------------------------
// pf74_in_if: command channel of the Playfair cipher
// Valid/ready channel carrying one command and its character per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface pf74_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [7:0] symbol;

  modport source (output valid, cmd, symbol, input ready);
  modport sink   (input valid, cmd, symbol, output ready);
endinterface

`default_nettype wire

// File: rtl/core/pf74_out_if.sv
// ----------------------------------------------------------------------------
// pf74_out_if: result channel of the Playfair cipher
// Valid/ready channel carrying one result character per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface pf74_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last;
  logic       error;

  modport source (output valid, out_char, last, error, input ready);
  modport sink   (input valid, out_char, last, error, output ready);
endinterface

`default_nettype wire

// File: rtl/core/pf74_place_mem.sv
// ----------------------------------------------------------------------------
// pf74_place_mem: symbol-to-cell map
// One synchronous memory of grid cell indexes, one entry per symbol code,
// with a valid bit per entry that marks the symbol as present in the grid.
// ----------------------------------------------------------------------------
`default_nettype none

module pf74_place_mem #(
  parameter int CELL_W = 5
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire pf74_pkg::place_ctl_t ctl,
  input  wire [CELL_W-1:0]          wdata,
  output logic                      rvalid,
  output logic [CELL_W-1:0]         rdata
);

  logic [CELL_W-1:0]        mem [pf74_pkg::NSYM];
  logic [pf74_pkg::NSYM-1:0] valid_r;
  logic                     rvalid_r;
  logic [CELL_W-1:0]        rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[ctl.waddr] <= wdata;
    end
    if (ctl.re) begin
      // A write to the entry being read is forwarded.
      if (ctl.we && ctl.waddr == ctl.raddr) begin
        rdata_r <= wdata;
      end else begin
        rdata_r <= mem[ctl.raddr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rvalid_r <= 1'b0;
    end else begin
      if (ctl.clr) begin
        valid_r <= '0;
      end else if (ctl.we) begin
        valid_r[ctl.waddr] <= 1'b1;
      end
      if (ctl.re) begin
        rvalid_r <= (ctl.we && !ctl.clr && ctl.waddr == ctl.raddr) || valid_r[ctl.raddr];
      end
    end
  end

  assign rvalid = rvalid_r;
  assign rdata  = rdata_r;

endmodule

`default_nettype wire

// File: rtl/core/pf74_grid_mem.sv
// ----------------------------------------------------------------------------
// pf74_grid_mem: key grid storage
// One synchronous memory holding the symbol code of each grid cell.
// ----------------------------------------------------------------------------
`default_nettype none

module pf74_grid_mem #(
  parameter int CELLS  = 28,
  parameter int CELL_W = 5
) (
  input  wire                      clk,
  input  wire pf74_pkg::grid_ctl_t ctl,
  input  wire [CELL_W-1:0]         waddr,
  input  wire [CELL_W-1:0]         raddr,
  output logic [pf74_pkg::SYM_W-1:0] rdata
);

  logic [pf74_pkg::SYM_W-1:0] mem [CELLS];
  logic [pf74_pkg::SYM_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[waddr] <= ctl.wdata;
    end
    if (ctl.re) begin
      if (ctl.we && waddr == raddr) begin
        rdata_r <= ctl.wdata;
      end else begin
        rdata_r <= mem[raddr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: rtl/core/pf74_pair.sv
// ----------------------------------------------------------------------------
// pf74_pair: digraph rule
// Maps the cells of a digraph to the cells of its two result characters by
// the row, column and rectangle rules, forward or backward.
// ----------------------------------------------------------------------------
`default_nettype none

module pf74_pair #(
  parameter int GRID_ROWS = 7,
  parameter int CELL_W    = 5
) (
  input  wire [CELL_W-1:0] p1,
  input  wire [CELL_W-1:0] p2,
  input  wire              back,
  output logic [CELL_W-1:0] q1,
  output logic [CELL_W-1:0] q2
);

  localparam int ROW_W = CELL_W - pf74_pkg::COL_W;
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(GRID_ROWS - 1);

  logic [ROW_W-1:0]          r1, r2, r1s, r2s;
  logic [pf74_pkg::COL_W-1:0] c1, c2, c1s, c2s;

  function automatic logic [ROW_W-1:0] row_step(input logic [ROW_W-1:0] r,
                                                input logic bk);
    if (bk) begin
      return (r == '0) ? ROW_LAST : r - ROW_W'(1);
    end
    return (r == ROW_LAST) ? '0 : r + ROW_W'(1);
  endfunction

  always_comb begin
    r1 = p1[CELL_W-1:pf74_pkg::COL_W];
    r2 = p2[CELL_W-1:pf74_pkg::COL_W];
    c1 = p1[pf74_pkg::COL_W-1:0];
    c2 = p2[pf74_pkg::COL_W-1:0];
    // Column shift wraps naturally in the column field width.
    c1s = back ? c1 - pf74_pkg::COL_W'(1) : c1 + pf74_pkg::COL_W'(1);
    c2s = back ? c2 - pf74_pkg::COL_W'(1) : c2 + pf74_pkg::COL_W'(1);
    r1s = row_step(r1, back);
    r2s = row_step(r2, back);
    if (r1 == r2) begin
      q1 = {r1, c1s};
      q2 = {r2, c2s};
    end else if (c1 == c2) begin
      q1 = {r1s, c1};
      q2 = {r2s, c2};
    end else begin
      q1 = {r1, c2};
      q2 = {r2, c1};
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/playfair_7x4_cipher_top.sv
// ----------------------------------------------------------------------------
// playfair_7x4_cipher_top: Playfair cipher on a GRID_ROWS x 4 grid
// Builds the key grid from streamed key letters and enciphers or deciphers
// digraphs through two memories: the grid and the symbol-to-cell map.
// ----------------------------------------------------------------------------
// Sequence: key_start and key_char are handled in the idle state; key_done
// walks every symbol code (S_FILL) and then marks the empty cells (S_PAD); a
// held symbol is looked up (S_LOOK); a digraph passes S_LOOK (and S_XLOOK for
// a pad x or a doubled letter), S_CALC, S_G1, S_G2, S_EMIT1 and S_EMIT2.
// One item at a time: the input is taken only while the sequencer is idle,
// so a digraph item holds it until both results are in the output register.
// Reset: synchronous, active low; clears the key, map valid bits and output.
// ----------------------------------------------------------------------------
`default_nettype none

module playfair_7x4_cipher_top #(
  parameter int GRID_ROWS = 7
) (
  input  wire         clk,
  input  wire         rst_n,
  pf74_in_if.sink     in_ch,
  pf74_out_if.source  out_ch
);

  // Grid geometry. The grid always has four columns, so a cell index is a
  // row field above a two-bit column field.
  localparam int CELLS  = GRID_ROWS * pf74_pkg::GRID_COLS;
  localparam int CELL_W = $clog2(CELLS);
  localparam int FILL_W = $clog2(CELLS + 1);
  localparam int SYM_W  = pf74_pkg::SYM_W;

  // The sequencer. S_FILL walks every symbol code once after key_done,
  // S_PAD marks leftover cells empty. A cipher symbol is looked up in the
  // map (S_LOOK); a pad x needs a second lookup (S_XLOOK). S_CALC applies
  // the digraph rule, S_G1/S_G2 read the two result cells from the grid.
  typedef enum logic [3:0] {
    S_IDLE,
    S_FILL,
    S_PAD,
    S_LOOK,
    S_XLOOK,
    S_CALC,
    S_G1,
    S_G2,
    S_EMIT1,
    S_EMIT2,
    S_ERR
  } state_t;

  state_t state_r, state_nxt;

  logic                          key_ready_r, key_ready_nxt;
  logic [pf74_pkg::NUM_LETTERS-1:0] used_r, used_nxt;
  logic [FILL_W-1:0]             fill_r, fill_nxt;
  logic [SYM_W-1:0]              idx_r, idx_nxt;
  logic                          held_valid_r, held_valid_nxt;
  logic                          held_dec_r, held_dec_nxt;
  logic [SYM_W-1:0]              held_sym_r, held_sym_nxt;
  logic [CELL_W-1:0]             held_place_r, held_place_nxt;
  logic [SYM_W-1:0]              cur_code_r, cur_code_nxt;
  logic                          cur_back_r, cur_back_nxt;
  logic [CELL_W-1:0]             p1_r, p1_nxt, p2_r, p2_nxt;
  logic                          back_r, back_nxt;
  logic [CELL_W-1:0]             q2_r, q2_nxt;
  logic [SYM_W-1:0]              ch1_r, ch1_nxt, ch2_r, ch2_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [7:0]                    out_char_r, out_char_nxt;
  logic                          out_last_r, out_last_nxt;
  logic                          out_err_r, out_err_nxt;

  pf74_pkg::place_ctl_t pctl;
  logic [CELL_W-1:0]    p_wdata;
  logic                 p_rvalid;
  logic [CELL_W-1:0]    p_rdata;

  pf74_pkg::grid_ctl_t  gctl;
  logic [CELL_W-1:0]    g_waddr, g_raddr;
  logic [SYM_W-1:0]     g_rdata;

  logic [CELL_W-1:0]    q1, q2;

  logic                 in_fire;
  logic                 push_ok;
  logic [SYM_W-1:0]     in_code;
  logic [SYM_W-1:0]     in_code_i;
  logic                 in_space;
  logic                 in_digit;
  logic                 fill_room;
  logic                 held_same_mode;

  pf74_place_mem #(.CELL_W(CELL_W)) u_place (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (pctl),
    .wdata  (p_wdata),
    .rvalid (p_rvalid),
    .rdata  (p_rdata)
  );

  pf74_grid_mem #(.CELLS(CELLS), .CELL_W(CELL_W)) u_grid (
    .clk   (clk),
    .ctl   (gctl),
    .waddr (g_waddr),
    .raddr (g_raddr),
    .rdata (g_rdata)
  );

  pf74_pair #(.GRID_ROWS(GRID_ROWS), .CELL_W(CELL_W)) u_pair (
    .p1   (p1_r),
    .p2   (p2_r),
    .back (back_r),
    .q1   (q1),
    .q2   (q2)
  );

  // Items are taken only between commands; the output register lets the
  // next item in while a result waits downstream.
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign push_ok     = !out_valid_r || out_ch.ready;

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_char = out_char_r;
  assign out_ch.last     = out_last_r;
  assign out_ch.error    = out_err_r;

  assign in_code   = pf74_pkg::sym_code(in_ch.symbol);
  assign in_code_i = (in_code == pf74_pkg::CODE_J) ? pf74_pkg::CODE_I : in_code;
  assign in_space  = (in_ch.symbol == pf74_pkg::CH_SPACE) ||
                     (in_ch.symbol >= pf74_pkg::CH_TAB && in_ch.symbol <= pf74_pkg::CH_CR);
  assign in_digit  = (in_ch.symbol >= pf74_pkg::CH_0) && (in_ch.symbol <= pf74_pkg::CH_9);
  assign fill_room = (fill_r < FILL_W'(CELLS));
  // A held symbol from the other mode is dropped when a new one arrives.
  assign held_same_mode = held_valid_r && (held_dec_r == cur_back_r);

  always_comb begin
    state_nxt      = state_r;
    key_ready_nxt  = key_ready_r;
    used_nxt       = used_r;
    fill_nxt       = fill_r;
    idx_nxt        = idx_r;
    held_valid_nxt = held_valid_r;
    held_dec_nxt   = held_dec_r;
    held_sym_nxt   = held_sym_r;
    held_place_nxt = held_place_r;
    cur_code_nxt   = cur_code_r;
    cur_back_nxt   = cur_back_r;
    p1_nxt         = p1_r;
    p2_nxt         = p2_r;
    back_nxt       = back_r;
    q2_nxt         = q2_r;
    ch1_nxt        = ch1_r;
    ch2_nxt        = ch2_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_char_nxt   = out_char_r;
    out_last_nxt   = out_last_r;
    out_err_nxt    = out_err_r;

    pctl    = '0;
    p_wdata = fill_r[CELL_W-1:0];
    gctl    = '0;
    g_waddr = fill_r[CELL_W-1:0];
    g_raddr = q1;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_ch.cmd)
            pf74_pkg::CMD_KEY_START: begin
              pctl.clr       = 1'b1;
              used_nxt       = '0;
              fill_nxt       = '0;
              held_valid_nxt = 1'b0;
              held_dec_nxt   = 1'b0;
              held_sym_nxt   = '0;
              key_ready_nxt  = 1'b0;
            end
            pf74_pkg::CMD_KEY_CHAR: begin
              // Only new letters other than j are placed.
              if (!key_ready_r && in_code < SYM_W'(pf74_pkg::NUM_LETTERS) &&
                  in_code != pf74_pkg::CODE_J && !used_r[in_code[4:0]] && fill_room) begin
                used_nxt[in_code[4:0]] = 1'b1;
                pctl.we    = 1'b1;
                pctl.waddr = in_code;
                gctl.we    = 1'b1;
                gctl.wdata = in_code;
                fill_nxt   = fill_r + FILL_W'(1);
              end
            end
            pf74_pkg::CMD_KEY_DONE: begin
              if (!key_ready_r) begin
                idx_nxt   = '0;
                state_nxt = S_FILL;
              end
            end
            pf74_pkg::CMD_ENC_CHAR, pf74_pkg::CMD_DEC_CHAR: begin
              if (!key_ready_r) begin
                state_nxt = S_ERR;
              end else if (in_ch.cmd == pf74_pkg::CMD_ENC_CHAR && (in_space || in_digit)) begin
                state_nxt = S_IDLE;
              end else if (in_code_i == pf74_pkg::CODE_NONE) begin
                state_nxt = S_ERR;
              end else begin
                pctl.re      = 1'b1;
                pctl.raddr   = in_code_i;
                cur_code_nxt = in_code_i;
                cur_back_nxt = (in_ch.cmd == pf74_pkg::CMD_DEC_CHAR);
                state_nxt    = S_LOOK;
              end
            end
            pf74_pkg::CMD_END_MSG: begin
              if (held_valid_r) begin
                held_valid_nxt = 1'b0;
                if (held_dec_r) begin
                  state_nxt = S_ERR;
                end else begin
                  // Pad the odd plaintext letter with x.
                  p1_nxt     = held_place_r;
                  back_nxt   = 1'b0;
                  pctl.re    = 1'b1;
                  pctl.raddr = pf74_pkg::CODE_X;
                  state_nxt  = S_XLOOK;
                end
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_FILL: begin
        if ((idx_r < SYM_W'(pf74_pkg::NUM_LETTERS) && idx_r != pf74_pkg::CODE_J &&
             !used_r[idx_r[4:0]]) || idx_r >= SYM_W'(pf74_pkg::NUM_LETTERS)) begin
          if (fill_room) begin
            if (idx_r < SYM_W'(pf74_pkg::NUM_LETTERS)) begin
              used_nxt[idx_r[4:0]] = 1'b1;
            end
            pctl.we    = 1'b1;
            pctl.waddr = idx_r;
            gctl.we    = 1'b1;
            gctl.wdata = idx_r;
            fill_nxt   = fill_r + FILL_W'(1);
          end
        end
        idx_nxt = idx_r + SYM_W'(1);
        if (idx_r == SYM_W'(pf74_pkg::NSYM - 1)) begin
          state_nxt = S_PAD;
        end
      end

      S_PAD: begin
        if (fill_room) begin
          gctl.we    = 1'b1;
          gctl.wdata = pf74_pkg::CODE_NONE;
          fill_nxt   = fill_r + FILL_W'(1);
        end else begin
          key_ready_nxt  = 1'b1;
          held_valid_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end

      S_LOOK: begin
        if (!p_rvalid) begin
          state_nxt = S_ERR;
        end else if (!held_same_mode) begin
          held_valid_nxt = 1'b1;
          held_dec_nxt   = cur_back_r;
          held_sym_nxt   = cur_code_r;
          held_place_nxt = p_rdata;
          state_nxt      = S_IDLE;
        end else if (!cur_back_r && held_sym_r == cur_code_r) begin
          // Doubled letter: emit (held, x) and keep the letter held.
          p1_nxt     = held_place_r;
          back_nxt   = 1'b0;
          pctl.re    = 1'b1;
          pctl.raddr = pf74_pkg::CODE_X;
          state_nxt  = S_XLOOK;
        end else begin
          held_valid_nxt = 1'b0;
          p1_nxt         = held_place_r;
          p2_nxt         = p_rdata;
          back_nxt       = cur_back_r;
          state_nxt      = S_CALC;
        end
      end

      S_XLOOK: begin
        p2_nxt    = p_rdata;
        state_nxt = S_CALC;
      end

      S_CALC: begin
        gctl.re   = 1'b1;
        g_raddr   = q1;
        q2_nxt    = q2;
        state_nxt = S_G1;
      end

      S_G1: begin
        ch1_nxt   = g_rdata;
        gctl.re   = 1'b1;
        g_raddr   = q2_r;
        state_nxt = S_G2;
      end

      S_G2: begin
        ch2_nxt   = g_rdata;
        state_nxt = S_EMIT1;
      end

      S_EMIT1: begin
        if (push_ok) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = pf74_pkg::code_char(ch1_r);
          out_last_nxt  = 1'b0;
          out_err_nxt   = 1'b0;
          state_nxt     = S_EMIT2;
        end
      end

      S_EMIT2: begin
        if (push_ok) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = pf74_pkg::code_char(ch2_r);
          out_last_nxt  = 1'b1;
          out_err_nxt   = 1'b0;
          state_nxt     = S_IDLE;
        end
      end

      S_ERR: begin
        if (push_ok) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = 8'h00;
          out_last_nxt  = 1'b1;
          out_err_nxt   = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      key_ready_r  <= 1'b0;
      used_r       <= '0;
      fill_r       <= '0;
      idx_r        <= '0;
      held_valid_r <= 1'b0;
      held_dec_r   <= 1'b0;
      held_sym_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      key_ready_r  <= key_ready_nxt;
      used_r       <= used_nxt;
      fill_r       <= fill_nxt;
      idx_r        <= idx_nxt;
      held_valid_r <= held_valid_nxt;
      held_dec_r   <= held_dec_nxt;
      held_sym_r   <= held_sym_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    held_place_r <= held_place_nxt;
    cur_code_r   <= cur_code_nxt;
    cur_back_r   <= cur_back_nxt;
    p1_r         <= p1_nxt;
    p2_r         <= p2_nxt;
    back_r       <= back_nxt;
    q2_r         <= q2_nxt;
    ch1_r        <= ch1_nxt;
    ch2_r        <= ch2_nxt;
    out_char_r   <= out_char_nxt;
    out_last_r   <= out_last_nxt;
    out_err_r    <= out_err_nxt;
  end

  // The fill pointer never passes the end of the grid.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(CELLS))
    else $error("grid fill pointer beyond the last cell");

  // A digraph half can only be held once the grid is complete.
  a_held_needs_key: assert property (@(posedge clk) disable iff (!rst_n)
    held_valid_r |-> key_ready_r)
    else $error("symbol held without a complete key grid");

  // An error result always closes its group.
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_err_r |-> out_last_r)
    else $error("error result without last");

  // A map lookup always follows an accepted item.
  a_look_after_fire: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LOOK |-> $past(in_fire))
    else $error("symbol lookup without an accepted item");

  // The key becomes ready only at the end of the padding walk.
  a_ready_from_pad: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(key_ready_r) |-> $past(state_r == S_PAD))
    else $error("key ready raised outside the grid completion");

endmodule

`default_nettype wire
